// ----- src/hcle_pkg.sv -----
// ----------------------------------------------------------------------------
// hcle_pkg: shared types and constants of the Content-Length extractor
// Word types of both channels, the byte class word between the front and the
// back, character codes and the header key.
// ----------------------------------------------------------------------------
package hcle_pkg;

   localparam int QueueDepth  = 2;
   localparam int ResultDepth = 2;

   localparam int            ValueWidth = 63;
   localparam int            KeyLen     = 14;
   localparam logic [3:0]    KeyLast    = 4'(KeyLen);

   localparam logic [7:0] CharCr    = 8'h0D;
   localparam logic [7:0] CharLf    = 8'h0A;
   localparam logic [7:0] CharHt    = 8'h09;
   localparam logic [7:0] CharVt    = 8'h0B;
   localparam logic [7:0] CharFf    = 8'h0C;
   localparam logic [7:0] CharSpace = 8'h20;
   localparam logic [7:0] CharColon = 8'h3A;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;
   localparam logic [7:0] CaseBit   = 8'h20;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_word_type;

   typedef struct packed {
      logic                  length_found;
      logic [ValueWidth-1:0] length_value;
   } rsp_word_type;

   typedef struct packed {
      logic       is_cr;
      logic       is_lf;
      logic       is_colon;
      logic       is_blank;
      logic       is_plus;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit;
      logic [7:0] lower;
      logic       last;
   } byte_class_type;

   function automatic logic [7:0] key_char(input logic [3:0] pos);
      logic [7:0] ch;
      case (pos)
         4'd0:    ch = 8'h63; // c
         4'd1:    ch = 8'h6F; // o
         4'd2:    ch = 8'h6E; // n
         4'd3:    ch = 8'h74; // t
         4'd4:    ch = 8'h65; // e
         4'd5:    ch = 8'h6E; // n
         4'd6:    ch = 8'h74; // t
         4'd7:    ch = 8'h2D; // -
         4'd8:    ch = 8'h6C; // l
         4'd9:    ch = 8'h65; // e
         4'd10:   ch = 8'h6E; // n
         4'd11:   ch = 8'h67; // g
         4'd12:   ch = 8'h74; // t
         4'd13:   ch = 8'h68; // h
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

// ----- src/hcle_fifo.sv -----
// ----------------------------------------------------------------------------
// hcle_fifo: small register queue
// Holds words between two sides that stall independently; full and empty
// come straight from the fill count.
// ----------------------------------------------------------------------------
module hcle_fifo #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [Width-1:0] push_word,
   output logic             full,
   input  logic             pop,
   output logic [Width-1:0] pop_word,
   output logic             empty
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   logic [Width-1:0] mem_ff [Depth];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_word = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ----- src/hcle_front.sv -----
// ----------------------------------------------------------------------------
// hcle_front: byte classifier
// Accepts request bytes and turns each into a class word for the parser.
// ----------------------------------------------------------------------------
module hcle_front (
   input  logic                   req_push,
   input  hcle_pkg::req_word_type req_word,
   output logic                   req_full,
   input  logic                   q_full,
   output logic                   q_push,
   output hcle_pkg::byte_class_type q_word
);

   logic [7:0] c;
   logic       is_upper;

   assign c        = req_word.data_byte;
   assign is_upper = (c >= hcle_pkg::CharUpA) && (c <= hcle_pkg::CharUpZ);
   assign req_full = q_full;
   assign q_push   = req_push;

   always_comb begin
      q_word          = '0;
      q_word.is_cr    = (c == hcle_pkg::CharCr);
      q_word.is_lf    = (c == hcle_pkg::CharLf);
      q_word.is_colon = (c == hcle_pkg::CharColon);
      q_word.is_blank = c inside {hcle_pkg::CharSpace, hcle_pkg::CharHt, hcle_pkg::CharVt,
                                  hcle_pkg::CharFf, hcle_pkg::CharCr};
      q_word.is_plus  = (c == hcle_pkg::CharPlus);
      q_word.is_minus = (c == hcle_pkg::CharMinus);
      q_word.is_digit = (c >= hcle_pkg::CharZero) && (c <= hcle_pkg::CharNine);
      q_word.digit    = 4'(c - hcle_pkg::CharZero);
      q_word.lower    = is_upper ? (c | hcle_pkg::CaseBit) : c;
      q_word.last     = req_word.last_byte;
   end

endmodule

// ----- src/hcle_back.sv -----
// ----------------------------------------------------------------------------
// hcle_back: header parser
// Walks class words one per cycle if the result queue has room, tracks lines,
// key match, value digits and the CR LF CR LF terminator, and pushes answers.
// ----------------------------------------------------------------------------
module hcle_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  hcle_pkg::byte_class_type q_word,
   output logic                     q_pop,
   input  logic                     r_full,
   output logic                     r_push,
   output hcle_pkg::rsp_word_type   r_word
);

   typedef enum logic [2:0] {
      PhKey,
      PhSkip,
      PhBlank,
      PhSigned,
      PhDigits
   } phase_type;

   localparam int          VW       = hcle_pkg::ValueWidth;
   localparam int          PW       = VW + 4;
   localparam logic [1:0]  LciEmpty = 2'd0;
   localparam logic [1:0]  LciCr    = 2'd1;
   localparam logic [1:0]  LciOther = 2'd2;
   localparam logic [2:0]  TermNone = 3'd0;
   localparam logic [2:0]  TermCr   = 3'd1;
   localparam logic [2:0]  TermCrLf = 3'd2;
   localparam logic [2:0]  TermCr2  = 3'd3;
   localparam logic [2:0]  TermDone = 3'd4;

   phase_type      phase_ff, phase_in;
   logic [2:0]     term_ff, term_in;
   logic           in_req_ff, in_req_in;
   logic [3:0]     keypos_ff, keypos_in;
   logic [1:0]     lci_ff, lci_in;
   logic [VW-1:0]  acc_ff, acc_in;
   logic           neg_ff, neg_in;
   logic           decided_ff, decided_in;
   logic           valid_ff, valid_in;
   logic [VW-1:0]  value_ff, value_in;
   logic           hdone_ff, hdone_in;
   logic           fire;
   logic           emit;
   hcle_pkg::rsp_word_type emit_word;

   assign fire   = !q_empty && !r_full;
   assign q_pop  = fire;
   assign r_push = fire && emit;
   assign r_word = emit_word;

   always_comb begin
      logic [PW-1:0] prod;
      logic          take_ok;
      logic          dec_req;
      logic          dec_ok;
      logic [VW-1:0] dec_val;

      phase_in   = phase_ff;
      term_in    = term_ff;
      in_req_in  = in_req_ff;
      keypos_in  = keypos_ff;
      lci_in     = lci_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      decided_in = decided_ff;
      valid_in   = valid_ff;
      value_in   = value_ff;
      hdone_in   = hdone_ff;
      emit       = 1'b0;
      emit_word  = '0;
      dec_req    = 1'b0;
      dec_ok     = 1'b0;
      dec_val    = '0;

      prod    = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + PW'(q_word.digit);
      take_ok = (prod[PW-1:VW] == '0);

      if (fire) begin
         if (!hdone_ff) begin
            if (q_word.is_lf) begin
               if (in_req_ff) begin
                  in_req_in = 1'b0;
               end else if (!decided_ff) begin
                  unique case (phase_ff)
                     PhBlank, PhSigned: begin
                        dec_req = 1'b1;
                     end
                     PhDigits: begin
                        dec_req = 1'b1;
                        dec_ok  = !(neg_ff && (acc_ff != '0));
                        dec_val = acc_ff;
                     end
                     default: begin
                        dec_req = (lci_ff != LciOther);
                     end
                  endcase
               end
               phase_in  = PhKey;
               keypos_in = '0;
               lci_in    = LciEmpty;
               acc_in    = '0;
               neg_in    = 1'b0;
            end else if (!in_req_ff) begin
               lci_in = ((lci_ff == LciEmpty) && q_word.is_cr) ? LciCr : LciOther;
               if (!decided_ff) begin
                  unique case (phase_ff)
                     PhKey: begin
                        if (q_word.is_colon) begin
                           phase_in = (keypos_ff == hcle_pkg::KeyLast) ? PhBlank : PhSkip;
                        end else if ((keypos_ff < hcle_pkg::KeyLast) &&
                                     (q_word.lower == hcle_pkg::key_char(keypos_ff))) begin
                           keypos_in = keypos_ff + 1'b1;
                        end else begin
                           phase_in = PhSkip;
                        end
                     end
                     PhBlank: begin
                        if (q_word.is_blank) begin
                           phase_in = PhBlank;
                        end else if (q_word.is_plus) begin
                           phase_in = PhSigned;
                        end else if (q_word.is_minus) begin
                           neg_in   = 1'b1;
                           phase_in = PhSigned;
                        end else if (q_word.is_digit && take_ok) begin
                           acc_in   = prod[VW-1:0];
                           phase_in = PhDigits;
                        end else begin
                           dec_req = 1'b1;
                        end
                     end
                     PhSigned: begin
                        if (q_word.is_digit && take_ok) begin
                           acc_in   = prod[VW-1:0];
                           phase_in = PhDigits;
                        end else begin
                           dec_req = 1'b1;
                        end
                     end
                     PhDigits: begin
                        if (q_word.is_digit) begin
                           if (take_ok) begin
                              acc_in = prod[VW-1:0];
                           end else begin
                              dec_req = 1'b1;
                           end
                        end else begin
                           dec_req = 1'b1;
                           dec_ok  = !(neg_ff && (acc_ff != '0));
                           dec_val = acc_ff;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end

            if (dec_req) begin
               decided_in = 1'b1;
               valid_in   = dec_ok;
               value_in   = dec_ok ? dec_val : '0;
               if (!q_word.is_lf) begin
                  phase_in = PhSkip;
               end
            end

            if (q_word.is_cr) begin
               term_in = (term_ff == TermCrLf) ? TermCr2 : TermCr;
            end else if (q_word.is_lf) begin
               term_in = (term_ff == TermCr)  ? TermCrLf :
                         (term_ff == TermCr2) ? TermDone : TermNone;
            end else begin
               term_in = TermNone;
            end

            if (term_in == TermDone) begin
               hdone_in               = 1'b1;
               emit                   = 1'b1;
               emit_word.length_found = decided_in && valid_in;
               emit_word.length_value = (decided_in && valid_in) ? value_in : '0;
            end else if (q_word.last) begin
               emit = 1'b1;
            end
         end

         if (q_word.last) begin
            phase_in   = PhKey;
            term_in    = TermNone;
            in_req_in  = 1'b1;
            keypos_in  = '0;
            lci_in     = LciEmpty;
            acc_in     = '0;
            neg_in     = 1'b0;
            decided_in = 1'b0;
            valid_in   = 1'b0;
            value_in   = '0;
            hdone_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhKey;
         term_ff    <= TermNone;
         in_req_ff  <= 1'b1;
         keypos_ff  <= '0;
         lci_ff     <= LciEmpty;
         acc_ff     <= '0;
         neg_ff     <= 1'b0;
         decided_ff <= 1'b0;
         valid_ff   <= 1'b0;
         value_ff   <= '0;
         hdone_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         term_ff    <= term_in;
         in_req_ff  <= in_req_in;
         keypos_ff  <= keypos_in;
         lci_ff     <= lci_in;
         acc_ff     <= acc_in;
         neg_ff     <= neg_in;
         decided_ff <= decided_in;
         valid_ff   <= valid_in;
         value_ff   <= value_in;
         hdone_ff   <= hdone_in;
      end
   end

endmodule

// ----- src/http_content_length_extractor_core.sv -----
// ----------------------------------------------------------------------------
// http_content_length_extractor_core: Content-Length header extractor
// Parses an HTTP request byte stream and reports its first Content-Length.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_word (data_byte, last_byte) and raise req_push;
//   a word is taken at a clock edge where req_push is high and req_full low.
//   Set last_byte on the final byte of a buffer; the parser restarts after it.
//   Response channel: while rsp_empty is low, rsp_word holds the oldest answer
//   (length_found, length_value); raise rsp_pop to take it.
//   One answer comes per request: on the byte that completes CR LF CR LF, or
//   on the last byte (not found) when the terminator never appears.
//   Throughput: one byte per cycle while the result queue has room, set by the
//   parser step with its multiply-by-ten accumulator. The answer to a byte goes
//   through the class queue and the result queue before it shows on rsp_word.
//   A class queue sits between the classifier and the parser, and a result
//   queue after the parser; when the receiver stalls the result queue fills,
//   the parser holds, and req_full rises once the class queue is full.
//   Reset (synchronous, active high) empties both queues and restarts the
//   parser at the request line.
// ----------------------------------------------------------------------------
module http_content_length_extractor_core #(
   parameter int QUEUE_DEPTH  = hcle_pkg::QueueDepth,
   parameter int RESULT_DEPTH = hcle_pkg::ResultDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  hcle_pkg::req_word_type req_word,
   output logic                   req_full,
   input  logic                   rsp_pop,
   output hcle_pkg::rsp_word_type rsp_word,
   output logic                   rsp_empty
);

   localparam int ClassW = $bits(hcle_pkg::byte_class_type);
   localparam int RspW   = $bits(hcle_pkg::rsp_word_type);

   logic                     cq_push, cq_full, cq_pop, cq_empty;
   hcle_pkg::byte_class_type cq_in_word, cq_out_word;
   logic [ClassW-1:0]        cq_out_bits;
   logic                     rq_push, rq_full;
   hcle_pkg::rsp_word_type   rq_in_word;
   logic [RspW-1:0]          rq_out_bits;

   hcle_front u_front (
      .req_push (req_push),
      .req_word (req_word),
      .req_full (req_full),
      .q_full   (cq_full),
      .q_push   (cq_push),
      .q_word   (cq_in_word)
   );

   hcle_fifo #(
      .Width (ClassW),
      .Depth (QUEUE_DEPTH)
   ) u_class_q (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .push_word (ClassW'(cq_in_word)),
      .full      (cq_full),
      .pop       (cq_pop),
      .pop_word  (cq_out_bits),
      .empty     (cq_empty)
   );

   assign cq_out_word = hcle_pkg::byte_class_type'(cq_out_bits);

   hcle_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (cq_empty),
      .q_word  (cq_out_word),
      .q_pop   (cq_pop),
      .r_full  (rq_full),
      .r_push  (rq_push),
      .r_word  (rq_in_word)
   );

   hcle_fifo #(
      .Width (RspW),
      .Depth (RESULT_DEPTH)
   ) u_result_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_word (RspW'(rq_in_word)),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_word  (rq_out_bits),
      .empty     (rsp_empty)
   );

   assign rsp_word = hcle_pkg::rsp_word_type'(rq_out_bits);

endmodule

// ----- src/hcle_checker.sv -----
// ----------------------------------------------------------------------------
// hcle_checker: port-level checks of the Content-Length extractor
// Watches the top-level channels and flags words that break their rules.
// ----------------------------------------------------------------------------
module hcle_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_push,
   input hcle_pkg::req_word_type req_word,
   input logic                   req_full,
   input logic                   rsp_pop,
   input hcle_pkg::rsp_word_type rsp_word,
   input logic                   rsp_empty
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("queues not empty after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_word)))
      else $error("waiting response word changed");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_word.length_found) |-> (rsp_word.length_value == '0))
      else $error("length value nonzero when not found");

endmodule

bind http_content_length_extractor_core hcle_checker u_checker (.*);
